// File: hw/rtl/isoep_pkg.sv
// ----------------------------------------------------------------------------
// isoep_pkg
// shared types, widths and helpers for the timestamp to epoch parser
// ----------------------------------------------------------------------------
package isoep_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned EpochW = 39;

  // one input transaction: a single character of the timestamp string
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
    logic             empty_string;
  } in_t;

  // one output transaction: epoch seconds and validity
  typedef struct packed {
    logic signed [EpochW-1:0] epoch_seconds;
    logic                     parse_ok;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;  // a character transaction is taken this cycle
    logic step1;   // conversion: year/month terms and time products
    logic step2;   // conversion: day count and time sums
    logic step3;   // conversion: day count to seconds
    logic load;    // conversion: final sum into the output register
  } cmd_t;

  // days from march 1 to the first of the given month (march-based year)
  function automatic logic [8:0] month_start_days(input logic [3:0] month);
    logic [8:0] res;
    res = 9'd0;
    case (month)
      4'd3:    res = 9'd0;
      4'd4:    res = 9'd31;
      4'd5:    res = 9'd61;
      4'd6:    res = 9'd92;
      4'd7:    res = 9'd122;
      4'd8:    res = 9'd153;
      4'd9:    res = 9'd184;
      4'd10:   res = 9'd214;
      4'd11:   res = 9'd245;
      4'd12:   res = 9'd275;
      4'd1:    res = 9'd306;
      4'd2:    res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// File: hw/rtl/iso8601_to_epoch_parser_unit.sv
// ----------------------------------------------------------------------------
// iso8601_to_epoch_parser_unit
// streams a timestamp string and returns unix epoch seconds in utc
// ----------------------------------------------------------------------------
//  channel  signals                           transaction
//  -------  --------------------------------  ------------------------------
//  in       in_valid_i, in_ready_o, in_i      one character of the string
//  out      out_valid_o, out_ready_i, out_o   epoch seconds and parse flag
//
//  characters are taken one per cycle while a string is streaming in.
//  after the last character (or an empty-string marker) in_ready_o drops for
//  the conversion states ST_CV1 to ST_CV3 and the load state ST_CV4, which
//  registers the result in the output register and returns to intake.
//  a full output register stalls only that load state, which holds in_ready_o
//  low until out_ready_i frees it. reset clears all parser state.
// ----------------------------------------------------------------------------
module iso8601_to_epoch_parser_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  isoep_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output isoep_pkg::out_t out_o
);

  isoep_pkg::cmd_t cmd;

  // sequencer
  isoep_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_i.last_char),
    .in_empty_i  (in_i.empty_string),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // parser and conversion datapath
  isoep_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

// File: hw/rtl/isoep_ctrl.sv
// ----------------------------------------------------------------------------
// isoep_ctrl
// sequencer: character intake, four conversion steps, output handshake
// ----------------------------------------------------------------------------
module isoep_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  logic               in_empty_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output isoep_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_PARSE = 3'd0;
  localparam logic [2:0] ST_CV1   = 3'd1;
  localparam logic [2:0] ST_CV2   = 3'd2;
  localparam logic [2:0] ST_CV3   = 3'd3;
  localparam logic [2:0] ST_CV4   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_PARSE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_last_i || in_empty_i) begin
            state_d = ST_CV1;
          end
        end
      end
      ST_CV1: begin
        cmd_o.step1 = 1'b1;
        state_d     = ST_CV2;
      end
      ST_CV2: begin
        cmd_o.step2 = 1'b1;
        state_d     = ST_CV3;
      end
      ST_CV3: begin
        cmd_o.step3 = 1'b1;
        state_d     = ST_CV4;
      end
      ST_CV4: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PARSE;
        end
      end
      default: begin
        state_d = ST_PARSE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/isoep_dpath.sv
// ----------------------------------------------------------------------------
// isoep_dpath
// character parser registers, days-from-civil pipeline and output register
// ----------------------------------------------------------------------------
module isoep_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  isoep_pkg::cmd_t cmd_i,
  input  isoep_pkg::in_t  in_i,
  output isoep_pkg::out_t out_o
);

  localparam int unsigned EpochW = isoep_pkg::EpochW;

  localparam logic [3:0] PH_YEAR  = 4'd0;
  localparam logic [3:0] PH_MONTH = 4'd1;
  localparam logic [3:0] PH_DAY   = 4'd2;
  localparam logic [3:0] PH_HOUR  = 4'd3;
  localparam logic [3:0] PH_MIN   = 4'd4;
  localparam logic [3:0] PH_SEC   = 4'd5;
  localparam logic [3:0] PH_TAIL  = 4'd6;
  localparam logic [3:0] PH_ZH    = 4'd7;
  localparam logic [3:0] PH_ZM    = 4'd8;
  localparam logic [3:0] PH_DONE  = 4'd9;

  // era length plus the 1970 shift, applied to a year biased by one era
  localparam logic signed [23:0] DayBias = 24'sd865565;

  // parser state
  logic [3:0]  phase_q, phase_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  min_q, min_d;
  logic [6:0]  sec_q, sec_d;
  logic        tsep_q, tsep_d;
  logic        zseen_q, zseen_d;
  logic        zneg_q, zneg_d;
  logic [6:0]  zh_q, zh_d;
  logic [6:0]  zm_q, zm_d;
  logic        ferr_q, ferr_d;
  logic        bad_q, bad_d;

  logic       is_digit, is_sign, is_colon;
  logic [3:0] dval;
  logic       clear_all;

  assign is_digit  = (in_i.char_code >= 8'h30) && (in_i.char_code <= 8'h39);
  assign is_sign   = (in_i.char_code == 8'h2b) || (in_i.char_code == 8'h2d);
  assign is_colon  = (in_i.char_code == 8'h3a);
  assign dval      = in_i.char_code[3:0];
  assign clear_all = cmd_i.load || (cmd_i.accept && in_i.empty_string);

  // times ten plus the new digit
  function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
    return (a << 3) + (a << 1) + {10'd0, d};
  endfunction

  function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
    return (a << 3) + (a << 1) + {3'd0, d};
  endfunction

  // per-character parse step
  always_comb begin
    phase_d = phase_q;
    dcnt_d  = dcnt_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    tsep_d  = tsep_q;
    zseen_d = zseen_q;
    zneg_d  = zneg_q;
    zh_d    = zh_q;
    zm_d    = zm_q;
    ferr_d  = ferr_q;
    bad_d   = bad_q;

    if (clear_all) begin
      phase_d = PH_YEAR;
      dcnt_d  = 3'd0;
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
      tsep_d  = 1'b0;
      zseen_d = 1'b0;
      zneg_d  = 1'b0;
      zh_d    = '0;
      zm_d    = '0;
      ferr_d  = 1'b0;
      bad_d   = cmd_i.accept;
    end else if (cmd_i.accept) begin
      if (in_i.char_code == 8'h54 || in_i.char_code == 8'h74 ||
          in_i.char_code == 8'h20) begin
        tsep_d = 1'b1;
      end
      if (!ferr_q) begin
        case (phase_q)
          PH_YEAR: begin
            if (is_digit && dcnt_q < 3'd4) begin
              year_d = acc14(year_q, dval);
              dcnt_d = dcnt_q + 3'd1;
            end else if (in_i.char_code == 8'h2d && dcnt_q != 3'd0) begin
              phase_d = PH_MONTH;
              dcnt_d  = 3'd0;
            end else begin
              ferr_d = 1'b1;
            end
          end
          PH_MONTH: begin
            if (is_digit && dcnt_q < 3'd2) begin
              month_d = acc7(month_q, dval);
              dcnt_d  = dcnt_q + 3'd1;
            end else if (in_i.char_code == 8'h2d && dcnt_q != 3'd0) begin
              phase_d = PH_DAY;
              dcnt_d  = 3'd0;
            end else begin
              ferr_d = 1'b1;
            end
          end
          PH_DAY: begin
            if (is_digit && dcnt_q < 3'd2) begin
              day_d  = acc7(day_q, dval);
              dcnt_d = dcnt_q + 3'd1;
            end else if (dcnt_q == 3'd0) begin
              ferr_d = 1'b1;
            end else begin
              phase_d = PH_HOUR;
              dcnt_d  = 3'd0;
            end
          end
          PH_HOUR, PH_MIN, PH_SEC: begin
            if (is_digit && dcnt_q < 3'd2) begin
              if (phase_q == PH_HOUR) begin
                hour_d = acc7(hour_q, dval);
              end else if (phase_q == PH_MIN) begin
                min_d = acc7(min_q, dval);
              end else begin
                sec_d = acc7(sec_q, dval);
              end
              dcnt_d = dcnt_q + 3'd1;
            end else if (is_colon && dcnt_q != 3'd0 && phase_q != PH_SEC) begin
              phase_d = phase_q + 4'd1;
              dcnt_d  = 3'd0;
            end else begin
              // time pattern broken: keep it only if seconds have a digit
              if (!(phase_q == PH_SEC && dcnt_q != 3'd0)) begin
                hour_d = '0;
                min_d  = '0;
                sec_d  = '0;
              end
              phase_d = PH_TAIL;
              dcnt_d  = 3'd0;
              if (tsep_q && is_sign) begin
                phase_d = PH_ZH;
                zneg_d  = (in_i.char_code == 8'h2d);
              end
            end
          end
          PH_TAIL: begin
            if (tsep_q && is_sign) begin
              phase_d = PH_ZH;
              dcnt_d  = 3'd0;
              zneg_d  = (in_i.char_code == 8'h2d);
            end
          end
          PH_ZH: begin
            if (is_digit && dcnt_q < 3'd2) begin
              zh_d    = acc7(zh_q, dval);
              zseen_d = 1'b1;
              dcnt_d  = dcnt_q + 3'd1;
            end else if (is_colon && dcnt_q != 3'd0) begin
              phase_d = PH_ZM;
              dcnt_d  = 3'd0;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_ZM: begin
            if (is_digit && dcnt_q < 3'd2) begin
              zm_d   = acc7(zm_q, dval);
              dcnt_d = dcnt_q + 3'd1;
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_YEAR;
      dcnt_q  <= 3'd0;
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      tsep_q  <= 1'b0;
      zseen_q <= 1'b0;
      zneg_q  <= 1'b0;
      zh_q    <= '0;
      zm_q    <= '0;
      ferr_q  <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      dcnt_q  <= dcnt_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      tsep_q  <= tsep_d;
      zseen_q <= zseen_d;
      zneg_q  <= zneg_d;
      zh_q    <= zh_d;
      zm_q    <= zm_d;
      ferr_q  <= ferr_d;
      bad_q   <= bad_d;
    end
  end

  // step 1: final checks, biased march-based year, products
  logic        ok_c, tzero_c;
  logic [13:0] ybias_c;
  logic [26:0] ydiv_prod_c;
  logic [8:0]  doy_c;

  assign ok_c = !bad_q && !ferr_q &&
                ((phase_q >= PH_HOUR) || (phase_q == PH_DAY && dcnt_q != 3'd0)) &&
                (month_q >= 7'd1) && (month_q <= 7'd12) &&
                (day_q >= 7'd1) && (day_q <= 7'd31);
  assign tzero_c = (phase_q == PH_HOUR) || (phase_q == PH_MIN) ||
                   (phase_q == PH_SEC && dcnt_q == 3'd0);
  // year plus one era, minus one for january and february
  assign ybias_c = year_q + 14'd400 - {13'd0, (month_q <= 7'd2)};
  // divide by 100 through a reciprocal, exact below 43699
  assign ydiv_prod_c = {13'd0, ybias_c} * 27'd5243;
  assign doy_c = isoep_pkg::month_start_days(month_q[3:0]) + {2'd0, day_q} - 9'd1;

  logic        ok_q;
  logic [21:0] p365_q;
  logic [11:0] yq4_q;
  logic [7:0]  q100_q;
  logic [8:0]  doy_q;
  logic [18:0] hsec_q;
  logic [12:0] msec_q;
  logic [6:0]  ssec_q;
  logic [18:0] zhsec_q;
  logic [12:0] zmsec_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step1) begin
      ok_q    <= ok_c;
      p365_q  <= {8'd0, ybias_c} * 22'd365;
      yq4_q   <= ybias_c[13:2];
      q100_q  <= ydiv_prod_c[26:19];
      doy_q   <= doy_c;
      hsec_q  <= tzero_c ? 19'd0 : {12'd0, hour_q} * 19'd3600;
      msec_q  <= tzero_c ? 13'd0 : {6'd0, min_q} * 13'd60;
      ssec_q  <= tzero_c ? 7'd0 : sec_q;
      zhsec_q <= {12'd0, zh_q} * 19'd3600;
      zmsec_q <= {6'd0, zm_q} * 13'd60;
    end
  end

  // step 2: day number relative to 1970-01-01, time of day, zone offset
  logic signed [23:0] days_q;
  logic [18:0]        tod_q;
  logic [18:0]        ofs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step2) begin
      days_q <= $signed({2'd0, p365_q}) + $signed({12'd0, yq4_q})
              - $signed({16'd0, q100_q}) + $signed({18'd0, q100_q[7:2]})
              + $signed({15'd0, doy_q}) - DayBias;
      tod_q  <= hsec_q + {6'd0, msec_q} + {12'd0, ssec_q};
      ofs_q  <= zhsec_q + {6'd0, zmsec_q};
    end
  end

  // step 3: days to seconds
  logic signed [EpochW-1:0] dsec_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step3) begin
      dsec_q <= EpochW'($signed({{(EpochW-24){days_q[23]}}, days_q}) *
                        $signed(EpochW'(86400)));
    end
  end

  // step 4: add time of day, apply zone offset, load output register
  logic signed [EpochW-1:0] tod_ext, ofs_ext, epoch_c;
  isoep_pkg::out_t          out_q;

  assign tod_ext = $signed({{(EpochW-19){1'b0}}, tod_q});
  assign ofs_ext = zseen_q ? $signed({{(EpochW-19){1'b0}}, ofs_q}) : '0;
  assign epoch_c = zneg_q ? (dsec_q + tod_ext + ofs_ext) : (dsec_q + tod_ext - ofs_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.epoch_seconds <= ok_q ? epoch_c : '0;
      out_q.parse_ok      <= ok_q;
    end
  end

  assign out_o = out_q;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the timestamp to epoch parser: streams directed and
// random timestamp strings one character per transaction, predicts epoch
// seconds and the parse flag in a behavioral parser, and compares every
// result transaction field by field under random stalls on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int          HOLD_CYCLES   = 600;
  localparam int          TAIL_CYCLES   = 16;
  localparam int          CHAR_BUDGET   = 1150;
  localparam int          MAX_REPORTS   = 10;

  localparam logic [7:0]  CH_ZERO  = "0";
  localparam logic [7:0]  CH_NINE  = "9";
  localparam logic [7:0]  CH_DASH  = "-";
  localparam logic [7:0]  CH_PLUS  = "+";
  localparam logic [7:0]  CH_COLON = ":";
  localparam logic [7:0]  CH_DOT   = ".";
  localparam logic [7:0]  CH_UPPER_T = "T";
  localparam logic [7:0]  CH_LOWER_T = "t";
  localparam logic [7:0]  CH_SPACE = " ";
  localparam logic [7:0]  CH_ZULU  = "Z";

  typedef enum logic [3:0] {
    PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MIN, PH_SEC,
    PH_TAIL, PH_ZONE_H, PH_ZONE_M, PH_DONE
  } phase_e;

  // how a string ends: last_char on its final byte, or an empty marker
  typedef enum int {TERM_LAST, TERM_EMPTY} term_e;

  // idle pattern of one channel side
  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_e;

  typedef struct {
    string           text;
    term_e           term;
    bit              typed;
    isoep_pkg::out_t want;
  } stamp_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  isoep_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  isoep_pkg::out_t out_data;

  isoep_pkg::out_t expected_epochs[$];
  logic [7:0]      stamp_q[$];
  stamp_row_t      stamp_rows[$];
  int              fail_count = 0;
  int              chars_sent = 0;
  bit              hold_request = 1'b0;
  int              send_mode = PACE_FULL;
  int              send_left = 0;
  int              recv_mode = PACE_FULL;
  int              recv_left = 0;

  // behavioral parser state
  phase_e      ps_phase;
  logic [2:0]  ps_ndig;
  logic [13:0] ps_year;
  logic [6:0]  ps_month, ps_day, ps_hour, ps_min, ps_sec;
  logic        ps_tsep, ps_zone, ps_zneg, ps_bad;
  logic [6:0]  ps_zh, ps_zm;

  iso8601_to_epoch_parser_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // behavioral parser
  // ---------------------------------------------------------------------------

  task automatic clear_time();
    ps_hour = '0;
    ps_min  = '0;
    ps_sec  = '0;
  endtask

  task automatic clear_parse_state();
    ps_phase = PH_YEAR;
    ps_ndig  = '0;
    ps_year  = '0;
    ps_month = '0;
    ps_day   = '0;
    clear_time();
    ps_tsep  = 1'b0;
    ps_zone  = 1'b0;
    ps_zneg  = 1'b0;
    ps_zh    = '0;
    ps_zm    = '0;
    ps_bad   = 1'b0;
  endtask

  // day count since 1970-01-01 from a proleptic gregorian date
  function automatic longint civil_days(input longint y, input longint m, input longint d);
    longint yy, era, yoe, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic scan_char(input logic [7:0] c);
    logic       is_dig, is_sign, sep_before;
    logic [3:0] dv;
    is_dig     = (c >= CH_ZERO) && (c <= CH_NINE);
    dv         = is_dig ? c[3:0] : 4'd0;
    is_sign    = (c == CH_PLUS) || (c == CH_DASH);
    sep_before = ps_tsep;
    if (c == CH_UPPER_T || c == CH_LOWER_T || c == CH_SPACE) ps_tsep = 1'b1;
    if (ps_bad) return;
    case (ps_phase)
      PH_YEAR: begin
        if (is_dig && ps_ndig < 4) begin
          ps_year = 14'(ps_year * 10 + dv);
          ps_ndig++;
        end else if (c == CH_DASH && ps_ndig >= 1) begin
          ps_phase = PH_MONTH;
          ps_ndig  = '0;
        end else begin
          ps_bad = 1'b1;
        end
      end
      PH_MONTH: begin
        if (is_dig && ps_ndig < 2) begin
          ps_month = 7'(ps_month * 10 + dv);
          ps_ndig++;
        end else if (c == CH_DASH && ps_ndig >= 1) begin
          ps_phase = PH_DAY;
          ps_ndig  = '0;
        end else begin
          ps_bad = 1'b1;
        end
      end
      // any byte ends the day once it has a digit, or two
      PH_DAY: begin
        if (is_dig && ps_ndig < 2) begin
          ps_day = 7'(ps_day * 10 + dv);
          ps_ndig++;
        end else if (ps_ndig == 0) begin
          ps_bad = 1'b1;
        end else begin
          ps_phase = PH_HOUR;
          ps_ndig  = '0;
        end
      end
      PH_HOUR, PH_MIN, PH_SEC: begin
        if (is_dig && ps_ndig < 2) begin
          if (ps_phase == PH_HOUR) ps_hour = 7'(ps_hour * 10 + dv);
          else if (ps_phase == PH_MIN) ps_min = 7'(ps_min * 10 + dv);
          else ps_sec = 7'(ps_sec * 10 + dv);
          ps_ndig++;
        end else if (c == CH_COLON && ps_ndig >= 1 && ps_phase != PH_SEC) begin
          ps_phase = (ps_phase == PH_HOUR) ? PH_MIN : PH_SEC;
          ps_ndig  = '0;
        end else begin
          // time pattern broken: keep it only when seconds have a digit
          if (!(ps_phase == PH_SEC && ps_ndig >= 1)) clear_time();
          ps_phase = PH_TAIL;
          ps_ndig  = '0;
          if (sep_before && is_sign) begin
            ps_phase = PH_ZONE_H;
            ps_zneg  = (c == CH_DASH);
          end
        end
      end
      PH_TAIL: begin
        if (sep_before && is_sign) begin
          ps_phase = PH_ZONE_H;
          ps_ndig  = '0;
          ps_zneg  = (c == CH_DASH);
        end
      end
      PH_ZONE_H: begin
        if (is_dig && ps_ndig < 2) begin
          ps_zh   = 7'(ps_zh * 10 + dv);
          ps_zone = 1'b1;
          ps_ndig++;
        end else if (c == CH_COLON && ps_ndig >= 1) begin
          ps_phase = PH_ZONE_M;
          ps_ndig  = '0;
        end else begin
          ps_phase = PH_DONE;
        end
      end
      PH_ZONE_M: begin
        if (is_dig && ps_ndig < 2) begin
          ps_zm = 7'(ps_zm * 10 + dv);
          ps_ndig++;
        end else begin
          ps_phase = PH_DONE;
        end
      end
      default: ;
    endcase
  endtask

  // advance the parser by one input transaction; fires when a result is due
  task automatic predict_epoch(input isoep_pkg::in_t item, output bit fires,
                               output isoep_pkg::out_t res);
    bit     ok;
    longint secs, ofs;
    res   = '0;
    fires = 1'b0;
    if (item.empty_string) begin
      fires = 1'b1;
      clear_parse_state();
      return;
    end
    scan_char(item.char_code);
    if (!item.last_char) return;
    fires = 1'b1;
    ok = !ps_bad && (ps_phase >= PH_HOUR || (ps_phase == PH_DAY && ps_ndig >= 1));
    if (ps_phase == PH_HOUR || ps_phase == PH_MIN || (ps_phase == PH_SEC && ps_ndig == 0))
      clear_time();
    if (ps_month < 1 || ps_month > 12 || ps_day < 1 || ps_day > 31) ok = 1'b0;
    if (ok) begin
      secs = civil_days(longint'(ps_year), longint'(ps_month), longint'(ps_day)) * 86400
           + longint'(ps_hour) * 3600 + longint'(ps_min) * 60 + longint'(ps_sec);
      if (ps_zone) begin
        ofs  = longint'(ps_zh) * 3600 + longint'(ps_zm) * 60;
        secs = ps_zneg ? secs + ofs : secs - ofs;
      end
      res.epoch_seconds = secs[isoep_pkg::EpochW-1:0];
    end
    res.parse_ok = ok;
    clear_parse_state();
  endtask

  // ---------------------------------------------------------------------------
  // pacing and transaction drivers
  // ---------------------------------------------------------------------------

  task automatic next_gap(inout int mode, inout int left, output int gap);
    if (left == 0) begin
      mode = $urandom_range(PACE_FULL, PACE_BURSTY);
      left = $urandom_range(16, 64);
    end
    left--;
    case (mode)
      PACE_FULL:   gap = 0;
      PACE_RANDOM: gap = $urandom_range(0, 18);
      default:     gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endtask

  // one character transaction, predicted once the handshake completes
  task automatic send_item(input isoep_pkg::in_t item, input bit typed,
                           input isoep_pkg::out_t want);
    int              gap;
    bit              fires;
    isoep_pkg::out_t res;
    next_gap(send_mode, send_left, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    predict_epoch(item, fires, res);
    if (fires) expected_epochs.push_back(typed ? want : res);
  endtask

  task automatic send_stamp(input term_e term, input bit typed,
                            input isoep_pkg::out_t want);
    isoep_pkg::in_t item;
    int             i;
    for (i = 0; i < stamp_q.size(); i++) begin
      item.char_code    = stamp_q[i];
      item.last_char    = (term == TERM_LAST) && (i == stamp_q.size() - 1);
      item.empty_string = 1'b0;
      send_item(item, typed && item.last_char, want);
    end
    if (term == TERM_EMPTY) begin
      item.char_code    = 8'($urandom_range(0, 255));
      item.last_char    = 1'($urandom_range(0, 1));
      item.empty_string = 1'b1;
      send_item(item, typed, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  task automatic add_row(input string text, input term_e term, input bit typed,
                         input longint epoch, input bit ok);
    stamp_row_t row;
    row.text               = text;
    row.term               = term;
    row.typed              = typed;
    row.want.epoch_seconds = epoch[isoep_pkg::EpochW-1:0];
    row.want.parse_ok      = ok;
    stamp_rows.push_back(row);
  endtask

  task automatic push_num(input int value, input int ndig);
    int div;
    div = 1;
    repeat (ndig - 1) div *= 10;
    repeat (ndig) begin
      stamp_q.push_back(CH_ZERO + 8'((value / div) % 10));
      div /= 10;
    end
  endtask

  task automatic push_field(input int lo, input int hi);
    int nd;
    nd = $urandom_range(1, 2);
    if (nd == 2 && $urandom_range(0, 3) != 0) push_num($urandom_range(lo, hi), 2);
    else push_num($urandom_range(0, 10 ** nd - 1), nd);
  endtask

  // random timestamp: mostly well formed, some broken, some plain noise
  task automatic build_stamp(output term_e term);
    int kind, nd, f, nfields, pick;
    stamp_q.delete();
    term = ($urandom_range(0, 11) == 0) ? TERM_EMPTY : TERM_LAST;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      term = TERM_EMPTY;
      return;
    end
    if (kind == 1) begin
      repeat ($urandom_range(1, 12)) stamp_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nd = $urandom_range(1, 4);
    push_num($urandom_range(0, 10 ** nd - 1), nd);
    stamp_q.push_back(CH_DASH);
    push_field(1, 12);
    stamp_q.push_back(CH_DASH);
    push_field(1, 31);
    if ($urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0:       stamp_q.push_back(CH_LOWER_T);
        1:       stamp_q.push_back(CH_SPACE);
        2:       stamp_q.push_back(8'($urandom_range(0, 255)));
        3:       stamp_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        default: stamp_q.push_back(CH_UPPER_T);
      endcase
      nfields = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 2);
      for (f = 0; f < nfields; f++) begin
        if (f > 0) stamp_q.push_back(CH_COLON);
        nd = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(1, 2);
        push_num($urandom_range(0, 10 ** nd - 1), nd);
      end
      if ($urandom_range(0, 3) == 0) begin
        stamp_q.push_back(CH_DOT);
        push_num($urandom_range(0, 999), $urandom_range(1, 3));
      end
      if ($urandom_range(0, 3) == 0) stamp_q.push_back(CH_ZULU);
      if ($urandom_range(0, 1) == 0) begin
        stamp_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
        if ($urandom_range(0, 7) != 0) begin
          nd = $urandom_range(1, 2);
          push_num($urandom_range(0, 10 ** nd - 1), nd);
          if ($urandom_range(0, 1) == 0) begin
            stamp_q.push_back(CH_COLON);
            nd = $urandom_range(0, 2);
            if (nd > 0) push_num($urandom_range(0, 10 ** nd - 1), nd);
          end
        end
      end
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) stamp_q.push_back(8'($urandom_range(0, 255)));
    end
    // occasional single-byte corruption anywhere in the string
    if ($urandom_range(0, 7) == 0)
      stamp_q[$urandom_range(0, stamp_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off, and the comparison
  // ---------------------------------------------------------------------------
  initial begin
    int              stall;
    isoep_pkg::out_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      next_gap(recv_mode, recv_left, stall);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_epochs.size() == 0) begin
        note_mismatch($sformatf("unexpected result transaction: epoch %0d ok %0b",
                                out_data.epoch_seconds, out_data.parse_ok));
      end else begin
        want = expected_epochs.pop_front();
        if (out_data.epoch_seconds !== want.epoch_seconds)
          note_mismatch($sformatf("epoch_seconds: expected %0d, got %0d",
                                  want.epoch_seconds, out_data.epoch_seconds));
        if (out_data.parse_ok !== want.parse_ok)
          note_mismatch($sformatf("parse_ok: expected %0b, got %0b",
                                  want.parse_ok, out_data.parse_ok));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    term_e term;
    int    nstamps;
    int    i, j;
    clear_parse_state();

    // directed strings; typed results only where they are obvious
    add_row("1970-01-01", TERM_LAST, 1, 0, 1);
    add_row("9999-12-31T23:59:59", TERM_LAST, 1, 64'sd253402300799, 1);
    add_row("0-1-1", TERM_LAST, 1, -64'sd62167219200, 1);
    add_row("1969-12-31T23:59:59", TERM_LAST, 1, -1, 1);
    add_row("", TERM_EMPTY, 1, 0, 0);
    add_row("2020-0", TERM_EMPTY, 1, 0, 0);
    add_row("1970-13-01", TERM_LAST, 1, 0, 0);
    add_row("2000-00-10", TERM_LAST, 1, 0, 0);
    add_row("2000-01-32", TERM_LAST, 1, 0, 0);
    add_row("+2000-01-01", TERM_LAST, 1, 0, 0);
    add_row(" 2000-01-01", TERM_LAST, 1, 0, 0);
    add_row("2000-1-", TERM_LAST, 1, 0, 0);
    add_row("12345-01-01", TERM_LAST, 1, 0, 0);
    add_row("2000-02-29T12:34:56.789Z", TERM_LAST, 0, 0, 0);
    add_row("2000-01-0112:34:56", TERM_LAST, 0, 0, 0);
    add_row("2000-01-01x12:00:00+05", TERM_LAST, 0, 0, 0);
    add_row("2000-01-01T12:34-08", TERM_LAST, 0, 0, 0);
    add_row("1999-12-31t99:99:99-99:99", TERM_LAST, 0, 0, 0);
    add_row("2000-01-01T00:00:00+", TERM_LAST, 0, 0, 0);
    add_row("2000-01-01 00:00:00Z+05:45", TERM_LAST, 0, 0, 0);
    add_row("1970-1-1 0:0:1+1:3", TERM_LAST, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < stamp_rows.size(); i++) begin
      stamp_q.delete();
      for (j = 0; j < stamp_rows[i].text.len(); j++) stamp_q.push_back(stamp_rows[i].text[j]);
      send_stamp(stamp_rows[i].term, stamp_rows[i].typed, stamp_rows[i].want);
    end

    // random strings; one long output hold-off and one full drain on the way
    nstamps = 0;
    while (chars_sent < CHAR_BUDGET) begin
      if (nstamps == 12) hold_request = 1'b1;
      if (nstamps == 30) begin
        in_valid <= 1'b0;
        while (expected_epochs.size() != 0) @(posedge clk);
      end
      build_stamp(term);
      send_stamp(term, 1'b0, '0);
      nstamps++;
    end
    in_valid <= 1'b0;

    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_epochs.size() != 0) note_mismatch("results still outstanding at end of run");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
